// ----- hw/rtl/pcrs_pkg.sv -----
package pcrs_pkg;

    typedef enum logic [1:0] {
        OP_ABSORB,
        OP_DRAIN,
        OP_TICK,
        OP_FRAME
    } op_t;

    typedef enum logic [1:0] {
        KIND_SEND,
        KIND_DONE,
        KIND_FAIL,
        KIND_REJECT
    } kind_t;

    localparam int VOLUME_W      = 26;
    localparam int PULSE_W       = 14;
    localparam int SPEED_W       = 16;
    localparam int TIMER_W       = 16;
    localparam int RETRY_W       = 4;
    localparam int ADDR_W        = 8;
    localparam int CODE_W        = 8;
    localparam int RESULT_TOTAL_W = 32;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_SPEED   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SMALL_ADDRESS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LARGE_ADDRESS = 3'd4;

    localparam logic [SPEED_W-1:0] RST_MOTOR_SPEED   = 16'd197;
    localparam logic [TIMER_W-1:0] RST_ACK_TIMEOUT   = 16'd500;
    localparam logic [RETRY_W-1:0] RST_RETRY_LIMIT   = 4'd5;
    localparam logic [ADDR_W-1:0]  RST_SMALL_ADDRESS = 8'd1;
    localparam logic [ADDR_W-1:0]  RST_LARGE_ADDRESS = 8'd0;

    localparam logic [CODE_W-1:0] CODE_ACK  = 8'hB1;
    localparam logic [CODE_W-1:0] CODE_DONE = 8'hB0;

    localparam logic [RETRY_W-1:0] RETRY_FULL = 4'd15;

    localparam logic signed [VOLUME_W-1:0] SMALL_MAX_NL = 26'sd130000;
    localparam logic signed [VOLUME_W-1:0] LARGE_MAX_NL = 26'sd20000000;

    // pulses = floor(vol * 10 / step_tenth_nl), done as vol * ceil(10 * 2^40 / step) >> 40;
    // exact for vol below 2^25 since vol * rounding error stays under 2^40
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = 32;
    localparam logic [63:0] SMALL_STEP_TENTH_NL = 64'd4154;
    localparam logic [63:0] LARGE_STEP_TENTH_NL = 64'd16616;
    localparam logic [63:0] SMALL_RECIP_FULL =
        ((64'd10 << RECIP_SHIFT) + SMALL_STEP_TENTH_NL - 64'd1) / SMALL_STEP_TENTH_NL;
    localparam logic [63:0] LARGE_RECIP_FULL =
        ((64'd10 << RECIP_SHIFT) + LARGE_STEP_TENTH_NL - 64'd1) / LARGE_STEP_TENTH_NL;
    localparam logic [RECIP_W-1:0] SMALL_RECIP = SMALL_RECIP_FULL[RECIP_W-1:0];
    localparam logic [RECIP_W-1:0] LARGE_RECIP = LARGE_RECIP_FULL[RECIP_W-1:0];

    typedef struct packed {
        logic [SPEED_W-1:0] motor_speed;
        logic [TIMER_W-1:0] ack_timeout_ms;
        logic [RETRY_W-1:0] retry_limit;
        logic [ADDR_W-1:0]  small_syringe_address;
        logic [ADDR_W-1:0]  large_syringe_address;
    } cfg_t;

    typedef struct packed {
        op_t                 opcode;
        logic [VOLUME_W-1:0] volume_nl;
        logic [CODE_W-1:0]   frame_code;
        logic [ADDR_W-1:0]   frame_address;
    } item_t;

    typedef struct packed {
        logic               reject;
        logic               is_large;
        logic [PULSE_W-1:0] pulses;
    } conv_t;

endpackage

// ----- hw/rtl/pcrs_if.sv -----
interface pcrs_in_if import pcrs_pkg::*;;
    logic                        valid;
    logic                        ready;
    op_t                         opcode;
    logic signed [VOLUME_W-1:0]  volume_nl;
    logic [CODE_W-1:0]           frame_code;
    logic [ADDR_W-1:0]           frame_address;

    modport source (output valid, opcode, volume_nl, frame_code, frame_address,
                    input ready);
    modport sink   (input valid, opcode, volume_nl, frame_code, frame_address,
                    output ready);
endinterface

interface pcrs_out_if import pcrs_pkg::*;;
    logic                              valid;
    logic                              ready;
    kind_t                             result_kind;
    logic [ADDR_W-1:0]                 target_address;
    logic                              move_direction;
    logic [PULSE_W-1:0]                pulse_count;
    logic [SPEED_W-1:0]                command_speed;
    logic signed [RESULT_TOTAL_W-1:0]  syringe_total_nl;

    modport source (output valid, result_kind, target_address, move_direction,
                    pulse_count, command_speed, syringe_total_nl,
                    input ready);
    modport sink   (input valid, result_kind, target_address, move_direction,
                    pulse_count, command_speed, syringe_total_nl,
                    output ready);
endinterface

// ----- hw/rtl/pcrs_pulse_conv.sv -----
module pcrs_pulse_conv
    import pcrs_pkg::*;
(
    input  logic [VOLUME_W-1:0] volume_nl,
    output conv_t               conv
);

    localparam int PROD_W = VOLUME_W - 1 + RECIP_W;

    logic signed [VOLUME_W-1:0] volume_s;
    logic [VOLUME_W-2:0]        magnitude;
    logic [RECIP_W-1:0]         recip;
    logic [PROD_W-1:0]          product;

    assign volume_s  = $signed(volume_nl);
    assign magnitude = volume_nl[VOLUME_W-2:0];

    always_comb
    begin
        conv.reject   = volume_s[VOLUME_W-1] || (volume_s > LARGE_MAX_NL);
        conv.is_large = volume_s > SMALL_MAX_NL;
        recip         = conv.is_large ? LARGE_RECIP : SMALL_RECIP;
        product       = PROD_W'(magnitude) * PROD_W'(recip);
        conv.pulses   = product[RECIP_SHIFT +: PULSE_W];
    end

endmodule

// ----- hw/rtl/pcrs_seq.sv -----
module pcrs_seq
    import pcrs_pkg::*;
#(
    parameter int TOTAL_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  item_t             item,
    input  conv_t             conv,
    input  cfg_t              cfg,
    output logic              advance,
    pcrs_out_if.source        out_ch
);

    localparam logic [PULSE_W-1:0] PULSE_MAX = 14'd12036;

    logic busy_reg, busy_next;
    logic ack_seen_reg, ack_seen_next;
    logic pending_large_reg, pending_large_next;
    logic pending_direction_reg, pending_direction_next;
    logic [PULSE_W-1:0] pending_pulses_reg, pending_pulses_next;
    logic [TIMER_W-1:0] elapsed_ms_reg, elapsed_ms_next;
    logic [RETRY_W-1:0] resend_count_reg, resend_count_next;
    logic signed [TOTAL_WIDTH-1:0] total_small_reg, total_small_next;
    logic signed [TOTAL_WIDTH-1:0] total_large_reg, total_large_next;

    logic                              out_valid_reg, out_valid_next;
    kind_t                             kind_reg, kind_next;
    logic [ADDR_W-1:0]                 address_reg, address_next;
    logic                              direction_reg, direction_next;
    logic [PULSE_W-1:0]                pulses_reg, pulses_next;
    logic [SPEED_W-1:0]                speed_reg, speed_next;
    logic signed [RESULT_TOTAL_W-1:0]  total_out_reg, total_out_next;

    logic                           emit;
    logic                           drain;
    logic                           pending_match;
    logic signed [TOTAL_WIDTH-1:0]  cur_total;
    logic signed [TOTAL_WIDTH-1:0]  new_total;
    logic signed [TOTAL_WIDTH-1:0]  sel_total;
    logic signed [TOTAL_WIDTH:0]    cur_ext;
    logic signed [TOTAL_WIDTH:0]    vol_ext;
    logic signed [TOTAL_WIDTH:0]    sum_ext;
    logic signed [TOTAL_WIDTH:0]    diff_ext;
    logic signed [TOTAL_WIDTH-1:0]  total_max;
    logic signed [TOTAL_WIDTH-1:0]  total_min;

    assign advance = item_valid && (!out_valid_reg || out_ch.ready);

    assign total_max = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
    assign total_min = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};

    assign drain         = (item.opcode == OP_DRAIN);
    assign pending_match = item.frame_address ==
        (pending_large_reg ? cfg.large_syringe_address : cfg.small_syringe_address);

    // saturating update of the selected syringe total
    always_comb
    begin
        cur_total = conv.is_large ? total_large_reg : total_small_reg;
        cur_ext   = (TOTAL_WIDTH+1)'(cur_total);
        vol_ext   = (TOTAL_WIDTH+1)'($signed(item.volume_nl));
        sum_ext   = cur_ext + vol_ext;
        diff_ext  = cur_ext - vol_ext;
        if (drain)
        begin
            new_total = (diff_ext[TOTAL_WIDTH] != diff_ext[TOTAL_WIDTH-1]) ?
                        total_min : diff_ext[TOTAL_WIDTH-1:0];
        end
        else
        begin
            new_total = (sum_ext[TOTAL_WIDTH] != sum_ext[TOTAL_WIDTH-1]) ?
                        total_max : sum_ext[TOTAL_WIDTH-1:0];
        end
    end

    always_comb
    begin
        busy_next              = busy_reg;
        ack_seen_next          = ack_seen_reg;
        pending_large_next     = pending_large_reg;
        pending_direction_next = pending_direction_reg;
        pending_pulses_next    = pending_pulses_reg;
        elapsed_ms_next        = elapsed_ms_reg;
        resend_count_next      = resend_count_reg;
        total_small_next       = total_small_reg;
        total_large_next       = total_large_reg;
        emit                   = 1'b0;
        kind_next              = kind_reg;

        if (advance)
        begin
            case (item.opcode)
                OP_ABSORB, OP_DRAIN:
                begin
                    if (!busy_reg)
                    begin
                        emit = 1'b1;
                        if (conv.reject)
                        begin
                            kind_next = KIND_REJECT;
                        end
                        else
                        begin
                            kind_next              = KIND_SEND;
                            pending_large_next     = conv.is_large;
                            pending_pulses_next    = conv.pulses;
                            pending_direction_next = drain;
                            if (conv.is_large)
                                total_large_next = new_total;
                            else
                                total_small_next = new_total;
                            busy_next         = 1'b1;
                            ack_seen_next     = 1'b0;
                            elapsed_ms_next   = '0;
                            resend_count_next = '0;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (busy_reg && !ack_seen_reg)
                    begin
                        if (elapsed_ms_reg < cfg.ack_timeout_ms)
                        begin
                            elapsed_ms_next = elapsed_ms_reg + 16'd1;
                        end
                        else
                        begin
                            elapsed_ms_next = '0;
                            emit            = 1'b1;
                            if (resend_count_reg > cfg.retry_limit ||
                                resend_count_reg == RETRY_FULL)
                            begin
                                busy_next = 1'b0;
                                kind_next = KIND_FAIL;
                            end
                            else
                            begin
                                resend_count_next = resend_count_reg + 4'd1;
                                kind_next         = KIND_SEND;
                            end
                        end
                    end
                end
                OP_FRAME:
                begin
                    if (busy_reg && pending_match)
                    begin
                        if (item.frame_code == CODE_ACK)
                        begin
                            ack_seen_next = 1'b1;
                        end
                        else if (item.frame_code == CODE_DONE)
                        begin
                            busy_next = 1'b0;
                            emit      = 1'b1;
                            kind_next = KIND_DONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result word
    always_comb
    begin
        sel_total      = pending_large_next ? total_large_next : total_small_next;
        speed_next     = cfg.motor_speed;
        if (kind_next == KIND_REJECT)
        begin
            address_next   = '0;
            direction_next = drain;
            pulses_next    = '0;
            total_out_next = '0;
        end
        else
        begin
            address_next   = pending_large_next ? cfg.large_syringe_address
                                                : cfg.small_syringe_address;
            direction_next = pending_direction_next;
            pulses_next    = pending_pulses_next;
            total_out_next = RESULT_TOTAL_W'(sel_total);
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg              <= 1'b0;
            ack_seen_reg          <= 1'b0;
            pending_large_reg     <= 1'b0;
            pending_direction_reg <= 1'b0;
            pending_pulses_reg    <= '0;
            elapsed_ms_reg        <= '0;
            resend_count_reg      <= '0;
            total_small_reg       <= '0;
            total_large_reg       <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            busy_reg              <= busy_next;
            ack_seen_reg          <= ack_seen_next;
            pending_large_reg     <= pending_large_next;
            pending_direction_reg <= pending_direction_next;
            pending_pulses_reg    <= pending_pulses_next;
            elapsed_ms_reg        <= elapsed_ms_next;
            resend_count_reg      <= resend_count_next;
            total_small_reg       <= total_small_next;
            total_large_reg       <= total_large_next;
            out_valid_reg         <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg      <= kind_next;
            address_reg   <= address_next;
            direction_reg <= direction_next;
            pulses_reg    <= pulses_next;
            speed_reg     <= speed_next;
            total_out_reg <= total_out_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.result_kind      = kind_reg;
    assign out_ch.target_address   = address_reg;
    assign out_ch.move_direction   = direction_reg;
    assign out_ch.pulse_count      = pulses_reg;
    assign out_ch.command_speed    = speed_reg;
    assign out_ch.syringe_total_nl = total_out_reg;

    // a command word always leaves a move in flight
    a_send_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit && kind_next == KIND_SEND |=> busy_reg)
        else $error("send word without busy");

    // done and failure both end the move
    a_end_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit && (kind_next == KIND_DONE || kind_next == KIND_FAIL) |=> !busy_reg)
        else $error("move still busy after done or failure");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_REJECT |->
        address_reg == '0 && pulses_reg == '0 && total_out_reg == '0)
        else $error("rejected word carries nonzero fields");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_SEND |-> pulses_reg <= PULSE_MAX)
        else $error("pulse count out of range");

endmodule

// ----- hw/rtl/pump_command_retry_sequencer.sv -----
// An accepted input word passes through the input register, then the result register,
// to become its result word; words that cause no result only update state.
// Throughput: one input word per cycle while out_ch.ready does not hold a pending result word;
// the state update path (pulse multiply, saturating total add, timeout compare) is combinational.
// Reset (rst_n, async, active low): idle, no move pending, both syringe totals zero,
// configuration registers back to their defaults.
module pump_command_retry_sequencer
    import pcrs_pkg::*;
#(
    parameter int TOTAL_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pcrs_in_if.sink                in_ch,
    pcrs_out_if.source             out_ch
);

    cfg_t  cfg_reg;
    logic  item_valid_reg, item_valid_next;
    item_t item_reg;
    conv_t conv;
    logic  advance;
    logic  in_take;

    assign in_ch.ready     = !item_valid_reg || advance;
    assign in_take         = in_ch.valid && in_ch.ready;
    assign item_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : item_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_speed           <= RST_MOTOR_SPEED;
            cfg_reg.ack_timeout_ms        <= RST_ACK_TIMEOUT;
            cfg_reg.retry_limit           <= RST_RETRY_LIMIT;
            cfg_reg.small_syringe_address <= RST_SMALL_ADDRESS;
            cfg_reg.large_syringe_address <= RST_LARGE_ADDRESS;
            item_valid_reg                <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MOTOR_SPEED:   cfg_reg.motor_speed    <= cfg_data;
                    REG_ACK_TIMEOUT:   cfg_reg.ack_timeout_ms <= cfg_data;
                    REG_RETRY_LIMIT:   cfg_reg.retry_limit    <= cfg_data[RETRY_W-1:0];
                    REG_SMALL_ADDRESS: cfg_reg.small_syringe_address <= cfg_data[ADDR_W-1:0];
                    REG_LARGE_ADDRESS: cfg_reg.large_syringe_address <= cfg_data[ADDR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode        <= in_ch.opcode;
            item_reg.volume_nl     <= in_ch.volume_nl;
            item_reg.frame_code    <= in_ch.frame_code;
            item_reg.frame_address <= in_ch.frame_address;
        end
    end

    pcrs_pulse_conv u_conv
    (
        .volume_nl (item_reg.volume_nl),
        .conv      (conv)
    );

    pcrs_seq #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .conv       (conv),
        .cfg        (cfg_reg),
        .advance    (advance),
        .out_ch     (out_ch)
    );

endmodule

// ----- tb/pump_command_retry_sequencer_tb.sv -----
module pump_command_retry_sequencer_tb;
    import pcrs_pkg::*;

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     FAIL_TICK_CAP  = 300;
    localparam int     PHASES         = 8;
    localparam longint TOTAL_MAX      = 64'sd2147483647;
    localparam longint TOTAL_MIN      = -TOTAL_MAX - 1;

    typedef struct {
        kind_t                     kind;
        logic [ADDR_W-1:0]         address;
        logic                      direction;
        logic [PULSE_W-1:0]        pulses;
        logic [SPEED_W-1:0]        speed;
        logic [RESULT_TOTAL_W-1:0] total;
    } move_word_t;

    class pump_scoreboard;
        cfg_t               cfg;
        bit                 busy;
        bit                 ack_seen;
        bit                 pend_large;
        bit                 pend_drain;
        bit [PULSE_W-1:0]   pend_pulses;
        bit [TIMER_W-1:0]   elapsed;
        bit [RETRY_W-1:0]   resends;
        longint             totals[2];
        move_word_t         awaited_words[$];
        int                 errors;

        function new();
            cfg = '{RST_MOTOR_SPEED, RST_ACK_TIMEOUT, RST_RETRY_LIMIT,
                    RST_SMALL_ADDRESS, RST_LARGE_ADDRESS};
        endfunction

        function logic [ADDR_W-1:0] pending_address();
            return pend_large ? cfg.large_syringe_address : cfg.small_syringe_address;
        endfunction

        function void await_pending(kind_t kind);
            move_word_t m;
            m.kind      = kind;
            m.address   = pending_address();
            m.direction = pend_drain;
            m.pulses    = pend_pulses;
            m.speed     = cfg.motor_speed;
            m.total     = totals[pend_large][RESULT_TOTAL_W-1:0];
            awaited_words.push_back(m);
        endfunction

        // returns 0 when the word leaves the block untouched
        function bit accept_event(item_t w);
            longint     vol;
            longint     t;
            move_word_t m;
            vol = longint'($signed(w.volume_nl));
            case (w.opcode)
                OP_ABSORB, OP_DRAIN:
                begin
                    if (busy)
                        return 0;
                    if (vol < 0 || vol > longint'(LARGE_MAX_NL))
                    begin
                        m.kind      = KIND_REJECT;
                        m.address   = '0;
                        m.direction = (w.opcode == OP_DRAIN);
                        m.pulses    = '0;
                        m.speed     = cfg.motor_speed;
                        m.total     = '0;
                        awaited_words.push_back(m);
                        return 1;
                    end
                    pend_large  = (vol > longint'(SMALL_MAX_NL));
                    pend_pulses = PULSE_W'((vol * 10) / (pend_large ?
                        longint'(LARGE_STEP_TENTH_NL) : longint'(SMALL_STEP_TENTH_NL)));
                    pend_drain  = (w.opcode == OP_DRAIN);
                    t = totals[pend_large];
                    if (pend_drain)
                        t = (t < TOTAL_MIN + vol) ? TOTAL_MIN : t - vol;
                    else
                        t = (t > TOTAL_MAX - vol) ? TOTAL_MAX : t + vol;
                    totals[pend_large] = t;
                    busy     = 1;
                    ack_seen = 0;
                    elapsed  = '0;
                    resends  = '0;
                    await_pending(KIND_SEND);
                    return 1;
                end
                OP_TICK:
                begin
                    if (!busy || ack_seen)
                        return 0;
                    if (elapsed < cfg.ack_timeout_ms)
                        elapsed++;
                    else
                    begin
                        elapsed = '0;
                        if (resends > cfg.retry_limit || resends == RETRY_FULL)
                        begin
                            busy = 0;
                            await_pending(KIND_FAIL);
                        end
                        else
                        begin
                            resends++;
                            await_pending(KIND_SEND);
                        end
                    end
                    return 1;
                end
                default:
                begin
                    if (!busy || w.frame_address != pending_address())
                        return 0;
                    if (w.frame_code == CODE_ACK)
                    begin
                        ack_seen = 1;
                        return 1;
                    end
                    if (w.frame_code == CODE_DONE)
                    begin
                        busy = 0;
                        await_pending(KIND_DONE);
                        return 1;
                    end
                    return 0;
                end
            endcase
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(move_word_t got);
            move_word_t want;
            if (awaited_words.size() == 0)
            begin
                $error("result word with none awaited, kind %0d", got.kind);
                errors++;
                return;
            end
            want = awaited_words.pop_front();
            compare("result_kind", want.kind, got.kind);
            compare("target_address", want.address, got.address);
            compare("move_direction", want.direction, got.direction);
            compare("pulse_count", want.pulses, got.pulses);
            compare("command_speed", want.speed, got.speed);
            compare("syringe_total_nl", longint'($signed(want.total)),
                    longint'($signed(got.total)));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int             src_idle_pct  = 0;
    int             snk_stall_pct = 0;
    int             counted_words = 0;
    int             quiet_cycles  = 0;
    pump_scoreboard sb;

    pcrs_in_if  in_ch();
    pcrs_out_if out_ch();

    pump_command_retry_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin : sample_result
        move_word_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.kind      = out_ch.result_kind;
            got.address   = out_ch.target_address;
            got.direction = out_ch.move_direction;
            got.pulses    = out_ch.pulse_count;
            got.speed     = out_ch.command_speed;
            got.total     = out_ch.syringe_total_nl;
            sb.check_word(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(op_t op, logic [VOLUME_W-1:0] vol,
                             logic [CODE_W-1:0] code, logic [ADDR_W-1:0] addr);
        item_t w;
        w.opcode        = op;
        w.volume_nl     = vol;
        w.frame_code    = code;
        w.frame_address = addr;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= op;
        in_ch.volume_nl     <= vol;
        in_ch.frame_code    <= code;
        in_ch.frame_address <= addr;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (sb.accept_event(w))
            counted_words++;
        @(negedge clk);
    endtask

    task automatic send_request(op_t op, logic [VOLUME_W-1:0] vol);
        send_word(op, vol, CODE_W'($urandom), ADDR_W'($urandom));
    endtask

    task automatic send_tick();
        send_word(OP_TICK, VOLUME_W'($urandom), CODE_W'($urandom), ADDR_W'($urandom));
    endtask

    task automatic send_frame(logic [CODE_W-1:0] code, logic [ADDR_W-1:0] addr);
        send_word(OP_FRAME, VOLUME_W'($urandom), code, addr);
    endtask

    // frame that must not match: right address with a foreign code, or wrong address
    task automatic send_stray_frame();
        logic [CODE_W-1:0] c;
        logic [ADDR_W-1:0] a;
        a = sb.pending_address();
        c = CODE_W'($urandom);
        if ($urandom_range(1))
        begin
            if (c == CODE_ACK || c == CODE_DONE)
                c = ~c;
        end
        else
        begin
            c = $urandom_range(1) ? CODE_ACK : CODE_DONE;
            a = a ^ ADDR_W'($urandom_range(255, 1));
        end
        send_frame(c, a);
    endtask

    function automatic logic [VOLUME_W-1:0] random_volume(bit heavy);
        int                  pick;
        logic [VOLUME_W-1:0] v;
        pick = $urandom_range(99);
        if (heavy && pick < 90)
            return VOLUME_W'(LARGE_MAX_NL);
        if (pick < 35)
            return VOLUME_W'($urandom_range(130000));
        if (pick < 45)
        begin
            case ($urandom_range(5))
                0:       return '0;
                1:       return VOLUME_W'(1);
                2:       return VOLUME_W'(SMALL_MAX_NL);
                3:       return VOLUME_W'(SMALL_MAX_NL) + 1'b1;
                4:       return VOLUME_W'(LARGE_MAX_NL) - 1'b1;
                default: return VOLUME_W'(LARGE_MAX_NL);
            endcase
        end
        if (pick < 88)
            return VOLUME_W'($urandom_range(20000000, 130001));
        if (pick < 94)
        begin
            v = VOLUME_W'($urandom);
            v[VOLUME_W-1] = 1'b1;
            return v;
        end
        return VOLUME_W'($urandom_range(33554431, 20000001));
    endfunction

    // request, ticks (sometimes up to failure), then maybe ack and done, with occasional stray frames
    task automatic run_move(int drain_pct, bit heavy);
        int to;
        int rl;
        int n;
        int ticks;
        send_request(($urandom_range(99) < drain_pct) ? OP_DRAIN : OP_ABSORB,
                     random_volume(heavy));
        if (!sb.busy)
            return;
        to = sb.cfg.ack_timeout_ms;
        rl = sb.cfg.retry_limit;
        if (heavy)
            ticks = $urandom_range(2);
        else if ((to + 1) * (rl + 2) <= FAIL_TICK_CAP && $urandom_range(3) == 0)
            ticks = (to + 1) * (rl + 2);
        else
            ticks = $urandom_range(to < 40 ? 3 * (to + 1) : 40);
        for (n = 0; n < ticks && sb.busy; n++)
        begin
            if ($urandom_range(19) == 0)
                send_stray_frame();
            send_tick();
        end
        if (!sb.busy)
            return;
        if ($urandom_range(9) < (heavy ? 3 : 7))
        begin
            send_frame(CODE_ACK, sb.pending_address());
            repeat ($urandom_range(3))
                send_tick();
            if ($urandom_range(9) == 0)
                send_frame(CODE_ACK, sb.pending_address());
        end
        if ($urandom_range(19) == 0)
            send_stray_frame();
        if ($urandom_range(99) < 85)
            send_frame(CODE_DONE, sb.pending_address());
    endtask

    task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic write_config(logic [SPEED_W-1:0] speed, logic [TIMER_W-1:0] timeout,
                                logic [RETRY_W-1:0] limit, logic [ADDR_W-1:0] small_addr,
                                logic [ADDR_W-1:0] large_addr);
        put_reg(REG_MOTOR_SPEED, speed);
        put_reg(REG_ACK_TIMEOUT, timeout);
        put_reg(REG_RETRY_LIMIT, CFG_DATA_W'(limit));
        put_reg(REG_SMALL_ADDRESS, CFG_DATA_W'(small_addr));
        put_reg(REG_LARGE_ADDRESS, CFG_DATA_W'(large_addr));
        cfg_write <= 1'b0;
        sb.cfg = '{speed, timeout, limit, small_addr, large_addr};
    endtask

    // hold the sender until every awaited word is out, then let the pipe drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.awaited_words.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    initial
    begin
        int                p;
        int                target;
        int                drain_pct;
        bit                heavy;
        logic [ADDR_W-1:0] shared_addr;

        sb = new();
        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.opcode        = OP_TICK;
        in_ch.volume_nl     = '0;
        in_ch.frame_code    = '0;
        in_ch.frame_address = '0;
        out_ch.ready        = 1'b0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset addresses: small syringe 1, large syringe 0
        send_tick();
        send_frame(CODE_DONE, 8'd1);
        send_request(OP_ABSORB, '0);
        send_frame(CODE_ACK, 8'd7);
        send_frame(8'h00, 8'd1);
        send_frame(CODE_ACK, 8'd1);
        send_frame(CODE_ACK, 8'd1);
        send_tick();
        send_frame(CODE_DONE, 8'd1);
        send_request(OP_ABSORB, VOLUME_W'(SMALL_MAX_NL));
        send_frame(CODE_DONE, 8'd1);
        send_request(OP_DRAIN, VOLUME_W'(SMALL_MAX_NL) + 1'b1);
        send_request(OP_ABSORB, VOLUME_W'(5));
        send_tick();
        send_frame(CODE_DONE, 8'd0);
        send_request(OP_DRAIN, VOLUME_W'(LARGE_MAX_NL));
        send_frame(CODE_ACK, 8'd0);
        send_frame(CODE_DONE, 8'd0);
        send_request(OP_ABSORB, VOLUME_W'(LARGE_MAX_NL) + 1'b1);
        send_request(OP_DRAIN, '1);
        send_request(OP_ABSORB, {1'b1, {(VOLUME_W-1){1'b0}}});
        send_request(OP_DRAIN, {1'b0, {(VOLUME_W-1){1'b1}}});
        send_request(OP_DRAIN, '0);
        send_frame(CODE_DONE, 8'd1);

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            // phases 5 and 6 push the large total into both saturation limits
            heavy     = (p == 5 || p == 6);
            drain_pct = (p == 5) ? 3 : (p == 6) ? 97 : 50;
            case (p)
                0: write_config('0, 16'd1, 4'd0, 8'd0, 8'd255);
                1: write_config('1, '1, '1, 8'd255, 8'd0);
                2: write_config(SPEED_W'($urandom), 16'd3, 4'd15,
                                ADDR_W'($urandom), ADDR_W'($urandom));
                3: write_config(RST_MOTOR_SPEED, RST_ACK_TIMEOUT, RST_RETRY_LIMIT,
                                RST_SMALL_ADDRESS, RST_LARGE_ADDRESS);
                4:
                begin
                    shared_addr = ADDR_W'($urandom);
                    write_config(SPEED_W'($urandom), TIMER_W'($urandom_range(8, 1)),
                                 RETRY_W'($urandom), shared_addr, shared_addr);
                end
                default: write_config(SPEED_W'($urandom), TIMER_W'($urandom_range(12, 1)),
                                      RETRY_W'($urandom), ADDR_W'($urandom),
                                      ADDR_W'($urandom));
            endcase
            src_idle_pct  = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 30 : 0;
            snk_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 30 : 0;
            target = counted_words + (heavy ? 450 : 140);
            while (counted_words < target)
            begin
                if ($urandom_range(19) == 0)
                    send_word(op_t'($urandom_range(3)), VOLUME_W'($urandom),
                              CODE_W'($urandom), ADDR_W'($urandom));
                else
                    run_move(drain_pct, heavy);
            end
        end

        in_ch.valid <= 1'b0;
        while (sb.awaited_words.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- pump_command_retry_sequencer.f -----
hw/rtl/pcrs_pkg.sv
hw/rtl/pcrs_if.sv
hw/rtl/pcrs_pulse_conv.sv
hw/rtl/pcrs_seq.sv
hw/rtl/pump_command_retry_sequencer.sv
tb/pump_command_retry_sequencer_tb.sv
